>>> rtl/thc_pkg.sv
// Package for the threshold histogram capture block: payload structs, opcodes,
// configuration register indexes and shared width constants.
// No dependencies.
`timescale 1ns / 1ps

package thc_pkg;

  localparam int unsigned DATA_W       = 16;
  localparam int unsigned INDEX_W      = 8;
  localparam int unsigned BIN_W        = 3;
  localparam int unsigned BIN_N        = 8;
  localparam int unsigned BORDER_N     = 7;
  localparam int unsigned FILL_OUT_W   = 9;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned BUFFER_DEPTH = 256;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_READ_BIN = 2'd2,
    OP_READ_CAP = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BORDER_COUNT = 3'd0,
    CFG_BORDER_A     = 3'd1,
    CFG_BORDER_B     = 3'd2,
    CFG_BORDER_C     = 3'd3,
    CFG_BORDER_D     = 3'd4,
    CFG_BORDER_E     = 3'd5,
    CFG_BORDER_F     = 3'd6,
    CFG_BORDER_G     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    op_e                opcode;
    logic [DATA_W-1:0]  sample;
    logic [INDEX_W-1:0] index;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0]     read_data;
    logic [BIN_W-1:0]      bin_hit;
    logic [FILL_OUT_W-1:0] fill_level;
    logic                  overflowed;
  } out_beat_t;

endpackage

>>> rtl/threshold_histogram_capture.sv
// Top level of the threshold histogram capture block: binning, bin counters,
// capture buffer and the two-register datapath. Depends on thc_pkg.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid_i / in_ready_o / in_i): one beat per command. ADD bins
//   and captures a sample, CLEAR zeroes counters, fill count and overflow flag,
//   READ_BIN and READ_CAP return a counter or a captured sample.
// - Output channel (out_valid_o / out_ready_i / out_o): exactly one beat per input
//   beat, in order. fill_level and overflowed reflect state after the command.
// - Config port (cfg_we_i, cfg_index_i, cfg_wdata_i): border count and seven borders, which
//   the user must write only while no command is in flight; not enforced. Counts are not cleared.
// - Flow: a beat taken into the input register moves on to the result register
//   when that is free or draining; a stalled output holds it back. Throughput: one
//   beat per cycle while the output is not stalled; all per-beat work (seven border
//   compares, one counter increment, a capture buffer read and for ADD a write)
//   happens between the input register and the result register.
// - Reset: counters, fill count, overflow flag, borders and valid bits clear at
//   once. Capture buffer contents are not cleared; the fill count masks them.
// - Stall: with out_ready_i low the result register holds; the input register
//   still takes one more beat, then in_ready_o drops until the output drains.
module threshold_histogram_capture #(
  parameter int unsigned BufferDepth = thc_pkg::BUFFER_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  thc_pkg::in_beat_t                   in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output thc_pkg::out_beat_t                  out_o,
  input  logic                                cfg_we_i,
  input  logic [thc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [thc_pkg::DATA_W-1:0]          cfg_wdata_i
);

  localparam int unsigned AddrW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int unsigned FillW = $clog2(BufferDepth + 1);
  localparam int unsigned CmpW  = (FillW > thc_pkg::INDEX_W) ? FillW : thc_pkg::INDEX_W;

  // config registers
  logic [thc_pkg::BIN_W-1:0]  border_count_q;
  logic [thc_pkg::DATA_W-1:0] borders_q [thc_pkg::BORDER_N];

  // histogram and capture state
  logic [thc_pkg::DATA_W-1:0] counts_q [thc_pkg::BIN_N];
  logic [FillW-1:0]           fill_q, fill_d;
  logic                       ovf_q, ovf_d;
  logic [thc_pkg::DATA_W-1:0] cap_mem [BufferDepth];
  logic [thc_pkg::DATA_W-1:0] cap_rd_q;

  // input stage
  logic              a_valid_q;
  thc_pkg::in_beat_t a_q;
  logic              a_adv;

  // result stage
  logic                          b_valid_q;
  logic                          b_sel_cap_q, b_sel_cap_d;
  logic [thc_pkg::DATA_W-1:0]    b_data_q, b_data_d;
  logic [thc_pkg::BIN_W-1:0]     b_hit_q, hit;
  logic [thc_pkg::FILL_OUT_W-1:0] b_fill_q;
  logic                          b_ovf_q;

  logic             cap_we;
  logic [AddrW-1:0] cap_wa, cap_ra;
  logic             cap_room;
  logic             idx_in_fill;

  // Stage A moves on when the result register is free or draining.
  assign a_adv      = a_valid_q && (!b_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || a_adv;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_count_q <= '0;
      for (int k = 0; k < thc_pkg::BORDER_N; k++) borders_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (thc_pkg::cfg_idx_e'(cfg_index_i))
        thc_pkg::CFG_BORDER_COUNT: border_count_q <= cfg_wdata_i[thc_pkg::BIN_W-1:0];
        thc_pkg::CFG_BORDER_A:     borders_q[0]   <= cfg_wdata_i;
        thc_pkg::CFG_BORDER_B:     borders_q[1]   <= cfg_wdata_i;
        thc_pkg::CFG_BORDER_C:     borders_q[2]   <= cfg_wdata_i;
        thc_pkg::CFG_BORDER_D:     borders_q[3]   <= cfg_wdata_i;
        thc_pkg::CFG_BORDER_E:     borders_q[4]   <= cfg_wdata_i;
        thc_pkg::CFG_BORDER_F:     borders_q[5]   <= cfg_wdata_i;
        thc_pkg::CFG_BORDER_G:     borders_q[6]   <= cfg_wdata_i;
      endcase
    end
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q <= in_i;
    end
  end

  // ---------------- bin selection ----------------
  // First border in use above the sample wins; none above means last bin.
  always_comb begin
    hit = border_count_q;
    for (int k = thc_pkg::BORDER_N - 1; k >= 0; k--) begin
      if ((thc_pkg::BIN_W'(k) < border_count_q) && (a_q.sample < borders_q[k])) begin
        hit = thc_pkg::BIN_W'(k);
      end
    end
  end

  // ---------------- capture bookkeeping ----------------
  assign cap_room    = fill_q < FillW'(BufferDepth);
  assign cap_we      = a_adv && (a_q.opcode == thc_pkg::OP_ADD) && cap_room;
  assign cap_wa      = AddrW'(fill_q);
  assign cap_ra      = AddrW'(a_q.index);
  assign idx_in_fill = CmpW'(a_q.index) < CmpW'(fill_q);

  always_comb begin
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    b_data_d    = '0;
    b_sel_cap_d = 1'b0;
    unique case (a_q.opcode)
      thc_pkg::OP_ADD: begin
        if (cap_room) fill_d = fill_q + FillW'(1);
        else          ovf_d  = 1'b1;
      end
      thc_pkg::OP_CLEAR: begin
        fill_d = '0;
        ovf_d  = 1'b0;
      end
      thc_pkg::OP_READ_BIN: begin
        if (a_q.index <= thc_pkg::INDEX_W'(border_count_q)) begin
          b_data_d = counts_q[a_q.index[thc_pkg::BIN_W-1:0]];
        end
      end
      thc_pkg::OP_READ_CAP: begin
        b_sel_cap_d = idx_in_fill;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      for (int k = 0; k < thc_pkg::BIN_N; k++) counts_q[k] <= '0;
    end else if (a_adv) begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      if (a_q.opcode == thc_pkg::OP_ADD) begin
        counts_q[hit] <= counts_q[hit] + thc_pkg::DATA_W'(1);
      end else if (a_q.opcode == thc_pkg::OP_CLEAR) begin
        for (int k = 0; k < thc_pkg::BIN_N; k++) counts_q[k] <= '0;
      end
    end
  end

  // Capture buffer: one write port at the fill count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cap_we) cap_mem[cap_wa] <= a_q.sample;
    if (a_adv)  cap_rd_q <= cap_mem[cap_ra];
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      b_sel_cap_q <= 1'b0;
    end else begin
      if (a_adv) begin
        b_valid_q   <= 1'b1;
        b_sel_cap_q <= b_sel_cap_d;
      end else if (out_ready_i) begin
        b_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_data_q <= b_data_d;
      b_hit_q  <= (a_q.opcode == thc_pkg::OP_ADD) ? hit : '0;
      b_fill_q <= thc_pkg::FILL_OUT_W'(fill_d);
      b_ovf_q  <= ovf_d;
    end
  end

  assign out_valid_o      = b_valid_q;
  assign out_o.read_data  = b_sel_cap_q ? cap_rd_q : b_data_q;
  assign out_o.bin_hit    = b_hit_q;
  assign out_o.fill_level = b_fill_q;
  assign out_o.overflowed = b_ovf_q;

  // ---------------- assertions ----------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(BufferDepth))
    else $error("fill count above buffer depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (fill_q == FillW'(BufferDepth)))
    else $error("overflow flag set with room in buffer");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_adv && (a_q.opcode == thc_pkg::OP_CLEAR)) |=>
      ((fill_q == '0) && !ovf_q && (b_fill_q == '0) && (b_hit_q == '0)))
    else $error("clear did not reset capture state");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv |-> (hit <= border_count_q))
    else $error("bin hit beyond bins in use");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !out_ready_i) |-> !a_adv)
    else $error("stage A advanced into a stalled result");

endmodule
